FILE: src/sha1_pkg.sv
// ----------------------------------------------------------------------------
// SHA-1 engine package
// Shared constants, command/status types and round functions.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1_pkg;

    localparam int BLOCK_BYTES  = 64;
    localparam int BLOCK_BITS   = BLOCK_BYTES * 8;
    localparam int FILL_W       = $clog2(BLOCK_BYTES);
    localparam int ROUNDS       = 80;
    localparam int ROUND_W      = $clog2(ROUNDS);
    localparam int DIGEST_WORDS = 5;
    localparam int WORD_IDX_W   = 3;

    localparam logic [FILL_W-1:0]     FILL_LAST      = FILL_W'(BLOCK_BYTES - 1);
    localparam logic [FILL_W-1:0]     FILL_LEN_START = FILL_W'(BLOCK_BYTES - 8);
    localparam logic [WORD_IDX_W-1:0] LAST_WORD_IDX  = WORD_IDX_W'(DIGEST_WORDS - 1);
    localparam logic [7:0]            PAD_MARKER     = 8'h80;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    localparam logic [31:0] K_0_19  = 32'h5a827999;
    localparam logic [31:0] K_20_39 = 32'h6ed9eba1;
    localparam logic [31:0] K_40_59 = 32'h8f1bbcdc;
    localparam logic [31:0] K_60_79 = 32'hca62c1d6;

    localparam logic [31:0] H_INIT [DIGEST_WORDS] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    typedef enum logic [1:0] {
        SRC_DATA,
        SRC_PAD,
        SRC_ZERO,
        SRC_LEN
    } byte_src_t;

    typedef enum logic [1:0] {
        GRP_0_19,
        GRP_20_39,
        GRP_40_59,
        GRP_60_79
    } round_grp_t;

    typedef struct packed {
        logic                  push_byte;
        byte_src_t             byte_src;
        logic                  count_bits;
        logic                  round_en;
        round_grp_t            round_grp;
        logic                  hash_add;
        logic                  restart;
        logic [WORD_IDX_W-1:0] word_idx;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [FILL_W-1:0] fill;
    } dp_sts_t;

    function automatic logic [31:0] round_f(round_grp_t grp, logic [31:0] b,
                                            logic [31:0] c, logic [31:0] d);
        logic [31:0] res;
        case (grp)
            GRP_0_19:  res = (b & c) | (~b & d);
            GRP_40_59: res = (b & c) | (b & d) | (c & d);
            default:   res = b ^ c ^ d;
        endcase
        return res;
    endfunction

    function automatic logic [31:0] round_k(round_grp_t grp);
        logic [31:0] res;
        case (grp)
            GRP_0_19:  res = K_0_19;
            GRP_20_39: res = K_20_39;
            GRP_40_59: res = K_40_59;
            default:   res = K_60_79;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: src/sha1_datapath.sv
// ----------------------------------------------------------------------------
// SHA-1 datapath
// Block shift register doubling as the message schedule window, byte fill
// count, message bit count, working variables and hash words.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_datapath (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire sha1_pkg::ctrl_cmd_t cmd,
    output sha1_pkg::dp_sts_t       sts,
    input  wire logic [7:0]         s_data_byte,
    output logic [31:0]             m_digest_word
);

    localparam int BB = sha1_pkg::BLOCK_BITS;

    logic [BB-1:0]                 blk_reg;
    logic [sha1_pkg::FILL_W-1:0]   fill_reg;
    logic [63:0]                   bits_reg;
    logic [31:0]                   hash_reg [sha1_pkg::DIGEST_WORDS];
    logic [31:0]                   a_reg, b_reg, c_reg, d_reg, e_reg;

    logic [7:0]  byte_in;
    logic [31:0] w0, w2, w8, w13, w_mix, w_new, temp;

    assign w0    = blk_reg[BB-1 -: 32];
    assign w2    = blk_reg[BB-1-2*32 -: 32];
    assign w8    = blk_reg[BB-1-8*32 -: 32];
    assign w13   = blk_reg[BB-1-13*32 -: 32];
    assign w_mix = w13 ^ w8 ^ w2 ^ w0;
    assign w_new = {w_mix[30:0], w_mix[31]};

    assign temp = {a_reg[26:0], a_reg[31:27]}
                + sha1_pkg::round_f(cmd.round_grp, b_reg, c_reg, d_reg)
                + e_reg + sha1_pkg::round_k(cmd.round_grp) + w0;

    always_comb begin
        case (cmd.byte_src)
            sha1_pkg::SRC_DATA: byte_in = s_data_byte;
            sha1_pkg::SRC_PAD:  byte_in = sha1_pkg::PAD_MARKER;
            sha1_pkg::SRC_LEN:  byte_in = bits_reg[{~fill_reg[2:0], 3'b000} +: 8];
            default:            byte_in = 8'h00;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.push_byte) begin
            blk_reg <= {blk_reg[BB-9:0], byte_in};
        end else if (cmd.round_en) begin
            blk_reg <= {blk_reg[BB-33:0], w_new};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.restart) begin
            fill_reg <= '0;
            bits_reg <= '0;
        end else begin
            if (cmd.push_byte) begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (cmd.count_bits) begin
                bits_reg <= bits_reg + 64'd8;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.restart) begin
            for (int i = 0; i < sha1_pkg::DIGEST_WORDS; i++) begin
                hash_reg[i] <= sha1_pkg::H_INIT[i];
            end
            a_reg <= sha1_pkg::H_INIT[0];
            b_reg <= sha1_pkg::H_INIT[1];
            c_reg <= sha1_pkg::H_INIT[2];
            d_reg <= sha1_pkg::H_INIT[3];
            e_reg <= sha1_pkg::H_INIT[4];
        end else if (cmd.round_en) begin
            e_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            b_reg <= a_reg;
            a_reg <= temp;
        end else if (cmd.hash_add) begin
            hash_reg[0] <= hash_reg[0] + a_reg;
            hash_reg[1] <= hash_reg[1] + b_reg;
            hash_reg[2] <= hash_reg[2] + c_reg;
            hash_reg[3] <= hash_reg[3] + d_reg;
            hash_reg[4] <= hash_reg[4] + e_reg;
            a_reg       <= hash_reg[0] + a_reg;
            b_reg       <= hash_reg[1] + b_reg;
            c_reg       <= hash_reg[2] + c_reg;
            d_reg       <= hash_reg[3] + d_reg;
            e_reg       <= hash_reg[4] + e_reg;
        end
    end

    always_comb begin
        case (cmd.word_idx)
            3'd0:    m_digest_word = hash_reg[0];
            3'd1:    m_digest_word = hash_reg[1];
            3'd2:    m_digest_word = hash_reg[2];
            3'd3:    m_digest_word = hash_reg[3];
            default: m_digest_word = hash_reg[4];
        endcase
    end

    assign sts.fill = fill_reg;

endmodule

`default_nettype wire

FILE: src/sha1_ctrl.sv
// ----------------------------------------------------------------------------
// SHA-1 controller
// Sequences byte loading, padding, the 80 compression rounds, the hash
// update and the output of the digest words.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_kind,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [2:0]                 m_word_index,
    output logic                       m_last_word,
    output sha1_pkg::ctrl_cmd_t        cmd,
    input  wire sha1_pkg::dp_sts_t     sts
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_ROUND,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    state_t                          state_reg, state_next;
    state_t                          ret_reg, ret_next;
    logic [sha1_pkg::ROUND_W-1:0]    round_reg, round_next;
    logic [sha1_pkg::WORD_IDX_W-1:0] idx_reg, idx_next;
    logic                            s_accept, block_full;

    assign s_ready    = (state_reg == ST_IDLE);
    assign s_accept   = s_valid && s_ready;
    assign block_full = (sts.fill == sha1_pkg::FILL_LAST);

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        round_next = round_reg;
        idx_next   = idx_reg;

        cmd            = '0;
        cmd.byte_src   = sha1_pkg::SRC_DATA;
        cmd.round_grp  = sha1_pkg::GRP_0_19;
        cmd.word_idx   = idx_reg;

        if (round_reg < sha1_pkg::ROUND_W'(20)) begin
            cmd.round_grp = sha1_pkg::GRP_0_19;
        end else if (round_reg < sha1_pkg::ROUND_W'(40)) begin
            cmd.round_grp = sha1_pkg::GRP_20_39;
        end else if (round_reg < sha1_pkg::ROUND_W'(60)) begin
            cmd.round_grp = sha1_pkg::GRP_40_59;
        end else begin
            cmd.round_grp = sha1_pkg::GRP_60_79;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    cmd.push_byte = 1'b1;
                    if (s_kind == sha1_pkg::KIND_FINISH) begin
                        cmd.byte_src = sha1_pkg::SRC_PAD;
                        state_next   = ST_PAD_ZERO;
                    end else begin
                        cmd.byte_src   = sha1_pkg::SRC_DATA;
                        cmd.count_bits = 1'b1;
                    end
                    if (block_full) begin
                        state_next = ST_ROUND;
                        ret_next   = (s_kind == sha1_pkg::KIND_FINISH) ? ST_PAD_ZERO : ST_IDLE;
                    end
                end
            end
            ST_PAD_ZERO: begin
                cmd.push_byte = 1'b1;
                if (sts.fill == sha1_pkg::FILL_LEN_START) begin
                    cmd.byte_src = sha1_pkg::SRC_LEN;
                    state_next   = ST_PAD_LEN;
                end else begin
                    cmd.byte_src = sha1_pkg::SRC_ZERO;
                    if (block_full) begin
                        state_next = ST_ROUND;
                        ret_next   = ST_PAD_ZERO;
                    end
                end
            end
            ST_PAD_LEN: begin
                cmd.push_byte = 1'b1;
                cmd.byte_src  = sha1_pkg::SRC_LEN;
                if (block_full) begin
                    state_next = ST_ROUND;
                    ret_next   = ST_EMIT;
                end
            end
            ST_ROUND: begin
                cmd.round_en = 1'b1;
                if (round_reg == sha1_pkg::ROUND_W'(sha1_pkg::ROUNDS - 1)) begin
                    round_next = '0;
                    state_next = ST_UPDATE;
                end else begin
                    round_next = round_reg + 1'b1;
                end
            end
            ST_UPDATE: begin
                cmd.hash_add = 1'b1;
                state_next   = ret_reg;
            end
            ST_EMIT: begin
                if (m_ready) begin
                    if (idx_reg == sha1_pkg::LAST_WORD_IDX) begin
                        cmd.restart = 1'b1;
                        idx_next    = '0;
                        state_next  = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            round_reg <= '0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            round_reg <= round_next;
            idx_reg   <= idx_next;
        end
    end

    assign m_valid      = (state_reg == ST_EMIT);
    assign m_word_index = idx_reg;
    assign m_last_word  = (idx_reg == sha1_pkg::LAST_WORD_IDX);

    a_round_range: assert property (@(posedge aclk) disable iff (!aresetn)
        round_reg <= sha1_pkg::ROUND_W'(sha1_pkg::ROUNDS - 1))
        else $error("round counter out of range");

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= sha1_pkg::LAST_WORD_IDX)
        else $error("digest word index out of range");

    a_push_xor_round: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.push_byte && (cmd.round_en || cmd.hash_add)))
        else $error("byte push during compression");

    a_round_after_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.push_byte && block_full) |=> (state_reg == ST_ROUND && round_reg == '0))
        else $error("full block did not start compression");

    a_update_after_round: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPDATE) |-> $past(state_reg == ST_ROUND))
        else $error("hash update without preceding rounds");

endmodule

`default_nettype wire

FILE: src/sha1_hash_engine.sv
// ----------------------------------------------------------------------------
// SHA-1 hash engine
// Input channel (s_): one transaction per message byte (s_kind = 0) or a
// finish transaction (s_kind = 1, s_data_byte ignored).
// Output channel (m_): after a finish, five transactions carry the digest,
// word 0 first, with m_last_word set on word 4.
// Data bytes are taken one per cycle while s_ready is high; the byte that
// completes a 64-byte block starts the 80 rounds of the single round unit
// and the hash update. A finish inserts 9 to 72 padding and length bytes at
// one per cycle, except while a completed block runs the rounds and the
// hash update; the first digest word is offered after the update of the last
// block, then one word per cycle while m_ready is high.
// s_ready is low while a block is compressed, during padding and while the
// digest is presented; a low m_ready holds the current word unchanged.
// After the fifth word is taken the engine restarts for a new message.
// Reset (aresetn low, synchronous) loads the initial hash values and
// clears the byte and bit counts.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_hash_engine (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_kind,
    input  wire logic [7:0]  s_data_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_digest_word,
    output logic [2:0]       m_word_index,
    output logic             m_last_word
);

    sha1_pkg::ctrl_cmd_t cmd;
    sha1_pkg::dp_sts_t   sts;

    sha1_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_word_index (m_word_index),
        .m_last_word  (m_last_word),
        .cmd          (cmd),
        .sts          (sts)
    );

    sha1_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_data_byte   (s_data_byte),
        .m_digest_word (m_digest_word)
    );

endmodule

`default_nettype wire
